FILE: rtl/core/rrvm_pkg.sv
// Package for the runtime region virtual mapper.
// Payload structs, the front-to-back work item and fixed constants.
// No dependencies.
package rrvm_pkg;

    localparam int unsigned PAGE_SHIFT  = 12;
    localparam int unsigned SZ_64K_LOG2 = 16;
    localparam int unsigned SZ_2M_LOG2  = 21;
    localparam int unsigned RUNTIME_BIT = 63;
    localparam int unsigned CACHE_BITS  = 4;   // UC WC WT WB
    localparam int unsigned COUNT_W     = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [63:0] SZ_64K = 64'(1) << SZ_64K_LOG2;
    localparam logic [63:0] SZ_2M  = 64'(1) << SZ_2M_LOG2;
    localparam logic [63:0] BASE_START_RST = 64'h0000_0000_2000_0000;

    typedef struct packed {
        logic [63:0] phys_address;
        logic [51:0] page_count;
        logic [3:0]  mem_type;
        logic [63:0] attribute;
        logic        last_of_map;
    } t_in_item;

    typedef struct packed {
        logic [63:0]        out_phys_address;
        logic [51:0]        out_page_count;
        logic [3:0]         out_mem_type;
        logic [63:0]        out_attribute;
        logic [63:0]        virtual_address;
        logic [COUNT_W-1:0] runtime_count;
    } t_out_item;

    // Classification handed from front to back
    typedef struct packed {
        logic first;      // first runtime descriptor of a map
        logic new_map;    // does not continue the previous region
        logic big_align;  // 2 MiB aligned and at least 2 MiB long
    } t_work_ctl;

    typedef struct packed {
        t_work_ctl                ctl;
        logic [63:0]              seed;    // base the map opens with
        logic [SZ_64K_LOG2-1:0]   offset;  // pa minus rounded start
        logic [63:0]              size;    // grown length in bytes
        logic [63:0]              phys_address;
        logic [51:0]              page_count;
        logic [3:0]               mem_type;
        logic [63:0]              attribute;
    } t_work;

endpackage

FILE: rtl/core/runtime_region_virtual_mapper_core.sv
// Top level of the runtime region virtual mapper.
// Depends on rrvm_pkg, rrvm_front, rrvm_fifo and rrvm_back.
//
// Takes one memory descriptor per cycle when full is low, sorted by physical
// address, and returns one result for each runtime descriptor: the descriptor
// with its virtual address and the running count of runtime regions in the map.
// Sustained rate is one descriptor per clock while the consumer pops; a
// descriptor that yields a result passes through the front-to-back queue,
// then the back end writes it to the result queue, where it can be taken.
// The rate is set by the back end, where the running virtual base (round up,
// then advance by the length) closes its loop combinationally around r_base.
// The base start register is read when a map opens: by its first descriptor
// if that one is a runtime region, otherwise as it stood when the previous
// map closed (the reset value before the first map).
module runtime_region_virtual_mapper_core #(
    parameter int unsigned ADDR_WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // descriptor side
    input  logic                push,
    output logic                full,
    input  rrvm_pkg::t_in_item  i_item,
    // result side
    output logic                empty,
    input  logic                pop,
    output rrvm_pkg::t_out_item o_result,
    // configuration: virtual base start
    input  logic                i_cfg_we,
    input  logic [63:0]         i_cfg_wdata
);
    import rrvm_pkg::*;

    logic [63:0] r_base_start;

    logic        accept;
    logic        front_wr;
    t_work       front_work;
    t_work       back_work;
    logic        work_empty;
    logic        res_full;
    logic        back_step;
    t_out_item   back_result;

    // Configuration register, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_start <= BASE_START_RST;
        end else if (i_cfg_we) begin
            r_base_start <= i_cfg_wdata;
        end
    end

    // A transfer happens when push is high and the work queue has room; non-runtime
    // descriptors only update the previous-region tracking.
    assign accept = push && !full;

    rrvm_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (i_item),
        .i_base_start (r_base_start),
        .o_wr         (front_wr),
        .o_work       (front_work)
    );

    // Decouples classification from address assignment
    rrvm_fifo #(
        .t_item (t_work)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_wdata (front_work),
        .o_full  (full),
        .i_rd    (back_step),
        .o_rdata (back_work),
        .o_empty (work_empty)
    );

    // Back end advances when there is work and room for its result
    assign back_step = !work_empty && !res_full;

    rrvm_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (back_step),
        .i_work       (back_work),
        .o_result     (back_result)
    );

    // Result queue: keeps the back end moving while the consumer stalls
    rrvm_fifo #(
        .t_item (t_out_item)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (back_step),
        .i_wdata (back_result),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (o_result),
        .o_empty (empty)
    );

endmodule

FILE: rtl/core/rrvm_fifo.sv
// Two-entry queue used between front and back and on the result side.
// Depends on nothing; payload type is a parameter.
module rrvm_fifo #(
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_item i_wdata,
    output logic  o_full,
    input  logic  i_rd,
    output t_item o_rdata,
    output logic  o_empty
);

    t_item       r_mem [2];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_count;
    logic        wr_en, rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (wr_en) r_wptr <= !r_wptr;
            if (rd_en) r_rptr <= !r_rptr;
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wptr] <= i_wdata;
    end

endmodule

FILE: rtl/core/rrvm_front.sv
// Front end: accepts descriptors, tracks the previous region, classifies.
// Depends on rrvm_pkg.
module rrvm_front #(
    parameter int unsigned ADDR_WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  rrvm_pkg::t_in_item i_item,
    input  logic [63:0]      i_base_start,
    output logic             o_wr,
    output rrvm_pkg::t_work  o_work
);
    import rrvm_pkg::*;

    localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_WIDTH);

    logic [63:0]           r_prev_end;
    logic [CACHE_BITS:0]   r_prev_attr;   // runtime bit and cache bits
    logic                  r_prev_valid;
    logic                  r_rt_seen;     // a runtime region already in this map
    logic [63:0]           r_map_base;    // base latched when the last map closed

    logic [63:0]           pa, size, region_end;
    logic [CACHE_BITS:0]   attr_key;
    logic                  runtime, continues;
    logic [SZ_64K_LOG2-1:0] offset;

    always_comb begin
        pa         = i_item.phys_address & ADDR_MASK;
        size       = {i_item.page_count, {PAGE_SHIFT{1'b0}}} & ADDR_MASK;
        region_end = (pa + size) & ADDR_MASK;
        attr_key   = {i_item.attribute[RUNTIME_BIT], i_item.attribute[CACHE_BITS-1:0]};
        runtime    = i_item.attribute[RUNTIME_BIT];
        continues  = r_prev_valid && (r_prev_end == pa) && (r_prev_attr == attr_key);
        offset     = continues ? '0 : pa[SZ_64K_LOG2-1:0];

        o_work.ctl.first     = !r_rt_seen;
        o_work.ctl.new_map   = !continues;
        // aligned to 2 MiB means no 64 KiB cut, so the length is unchanged
        o_work.ctl.big_align = (pa[SZ_2M_LOG2-1:0] == '0) && (size >= SZ_2M);
        // register read live by a map's first descriptor, else the closing value
        o_work.seed          = r_prev_valid ? r_map_base : (i_base_start & ADDR_MASK);
        o_work.offset        = offset;
        o_work.size          = (size + 64'(offset)) & ADDR_MASK;
        o_work.phys_address  = i_item.phys_address;
        o_work.page_count    = i_item.page_count;
        o_work.mem_type      = i_item.mem_type;
        o_work.attribute     = i_item.attribute;
        o_wr                 = i_accept && runtime;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_end   <= '0;
            r_prev_attr  <= '0;
            r_prev_valid <= 1'b0;
            r_rt_seen    <= 1'b0;
            r_map_base   <= BASE_START_RST & ADDR_MASK;
        end else if (i_accept) begin
            r_prev_end   <= region_end;
            r_prev_attr  <= attr_key;
            r_prev_valid <= !i_item.last_of_map;
            r_rt_seen    <= !i_item.last_of_map && (r_rt_seen || runtime);
            if (i_item.last_of_map) begin
                r_map_base <= i_base_start & ADDR_MASK;
            end
        end
    end

endmodule

FILE: rtl/core/rrvm_back.sv
// Back end: assigns virtual addresses and keeps the running base and count.
// Depends on rrvm_pkg.
module rrvm_back #(
    parameter int unsigned ADDR_WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  rrvm_pkg::t_work     i_work,
    output rrvm_pkg::t_out_item o_result
);
    import rrvm_pkg::*;

    localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_WIDTH);

    logic [63:0]        r_base;
    logic [COUNT_W-1:0] r_count;
    logic [63:0]        n_base;
    logic [COUNT_W-1:0] n_count;

    logic [63:0]        base_in, base, align_m1;
    logic [COUNT_W-1:0] count_in;

    always_comb begin
        base_in  = i_work.ctl.first ? i_work.seed : r_base;
        count_in = i_work.ctl.first ? '0 : r_count;
        align_m1 = i_work.ctl.big_align ? (SZ_2M - 64'd1) : (SZ_64K - 64'd1);
        if (i_work.ctl.new_map) begin
            base = ((base_in + align_m1) & ~align_m1) & ADDR_MASK;
        end else begin
            base = base_in;
        end
        n_base  = (base + i_work.size) & ADDR_MASK;
        n_count = (count_in == COUNT_MAX) ? COUNT_MAX : count_in + 1'b1;

        o_result.out_phys_address = i_work.phys_address;
        o_result.out_page_count   = i_work.page_count;
        o_result.out_mem_type     = i_work.mem_type;
        o_result.out_attribute    = i_work.attribute;
        o_result.virtual_address  = (base + 64'(i_work.offset)) & ADDR_MASK;
        o_result.runtime_count    = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_base  <= n_base;
            r_count <= n_count;
        end
    end

endmodule

FILE: sim/tb_runtime_region_virtual_mapper_core.sv
// Self-checking testbench for runtime_region_virtual_mapper_core.
// Drives descriptor maps, predicts each virtual mapping and checks every result transfer.
// Depends on rrvm_pkg and the mapper RTL only.
module tb_runtime_region_virtual_mapper_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rrvm_pkg::*;

    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned DRAIN_CYCLES = 6;    // result side lags a transfer
    localparam int unsigned QUIET_LIMIT  = 5000; // cycles with no transfer before giving up
    localparam int unsigned REPORT_CAP   = 200;
    localparam int unsigned STALL_CYCLES = 400;

    localparam logic [63:0] BASE_RESET = 64'h0000_0000_2000_0000;
    localparam logic [63:0] ATTR_RT    = 64'(1) << RUNTIME_BIT;
    localparam logic [63:0] ATTR_UC    = 64'h1;
    localparam logic [63:0] ATTR_WC    = 64'h2;
    localparam logic [63:0] ATTR_WB    = 64'h8;
    // bits that decide whether a region continues the previous one
    localparam logic [63:0] JOIN_MASK  = ATTR_RT | ((64'(1) << CACHE_BITS) - 64'(1));

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_in_item    i_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_out_item   o_result;
    logic        i_cfg_we = 1'b0;
    logic [63:0] i_cfg_wdata = '0;

    runtime_region_virtual_mapper_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mapping predictor: own copy of the register and the running state
    // ------------------------------------------------------------------
    logic [63:0] base_start_reg;
    logic [63:0] next_vbase;
    logic [63:0] last_region_end;
    logic [63:0] last_region_attr;
    bit          region_seen;
    logic [15:0] region_count;

    t_out_item   pending_mappings[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;

    // idling knobs, percent of cycles
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left = 0;

    // random map generator state
    logic [63:0] gen_addr = '0;
    logic [3:0]  gen_cache = 4'h8;
    int unsigned gen_left = 0;

    function automatic void restart_map_state();
        next_vbase       = base_start_reg;
        last_region_end  = '0;
        last_region_attr = '0;
        region_seen      = 1'b0;
        region_count     = '0;
    endfunction

    // Returns 1 and fills r when the descriptor yields a result.
    function automatic bit map_descriptor(input t_in_item d, output t_out_item r);
        logic [63:0] size;
        logic [63:0] region_end;
        logic [63:0] base;
        logic [63:0] start;
        bit          joins;
        bit          hit;
        size       = {d.page_count, 12'h000};
        region_end = d.phys_address + size;
        hit        = d.attribute[RUNTIME_BIT];
        r          = '0;
        if (hit) begin
            // register is only looked at by the first descriptor of a map
            base  = region_seen ? next_vbase : base_start_reg;
            start = d.phys_address;
            joins = region_seen && last_region_end == d.phys_address &&
                    ((last_region_attr ^ d.attribute) & JOIN_MASK) == '0;
            if (!joins) begin
                // new mapping: start drops to 64 KiB, length grows by the cut
                start = {d.phys_address[63:SZ_64K_LOG2], 16'h0000};
                size  = size + (d.phys_address - start);
                if (d.phys_address[SZ_2M_LOG2-1:0] == '0 && size >= SZ_2M)
                    base = (base + (SZ_2M - 64'(1))) & ~(SZ_2M - 64'(1));
                else
                    base = (base + (SZ_64K - 64'(1))) & ~(SZ_64K - 64'(1));
            end
            if (region_count != COUNT_MAX)
                region_count = region_count + 16'(1);
            r.out_phys_address = d.phys_address;
            r.out_page_count   = d.page_count;
            r.out_mem_type     = d.mem_type;
            r.out_attribute    = d.attribute;
            r.virtual_address  = base + (d.phys_address - start);
            r.runtime_count    = region_count;
            next_vbase = base + size;
        end
        // every descriptor, runtime or not, becomes the previous region
        last_region_end  = region_end;
        last_region_attr = d.attribute;
        region_seen      = 1'b1;
        if (d.last_of_map)
            restart_map_state();
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task automatic check_mapping(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (pending_mappings.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding (va %h)",
                                      results_seen, got.virtual_address));
            return;
        end
        want = pending_mappings.pop_front();
        if (got.out_phys_address !== want.out_phys_address)
            report_mismatch($sformatf("result %0d phys_address %h, want %h", results_seen,
                                      got.out_phys_address, want.out_phys_address));
        if (got.out_page_count !== want.out_page_count)
            report_mismatch($sformatf("result %0d page_count %h, want %h", results_seen,
                                      got.out_page_count, want.out_page_count));
        if (got.out_mem_type !== want.out_mem_type)
            report_mismatch($sformatf("result %0d mem_type %h, want %h", results_seen,
                                      got.out_mem_type, want.out_mem_type));
        if (got.out_attribute !== want.out_attribute)
            report_mismatch($sformatf("result %0d attribute %h, want %h", results_seen,
                                      got.out_attribute, want.out_attribute));
        if (got.virtual_address !== want.virtual_address)
            report_mismatch($sformatf("result %0d virtual_address %h, want %h", results_seen,
                                      got.virtual_address, want.virtual_address));
        if (got.runtime_count !== want.runtime_count)
            report_mismatch($sformatf("result %0d runtime_count %0d, want %0d", results_seen,
                                      got.runtime_count, want.runtime_count));
    endtask

    // Result side. Values read straight after the edge are the ones that
    // stood before it, so a transfer is push/pop high with empty/full low here.
    // A long hold-off, when asked for, is counted down in this process.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                check_mapping(o_result);
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run if nothing transfers for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Descriptor side
    // ------------------------------------------------------------------
    // Holds push high until the transfer; push is left high on return so the
    // next descriptor can follow back to back.
    task automatic send_descriptor(input t_in_item d);
        int unsigned gap;
        t_out_item   r;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 24)
            gap++;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= d;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        if (map_descriptor(d, r))
            pending_mappings.push_back(r);
    endtask

    // Drop push and let every outstanding result come out, then wait out DRAIN_CYCLES
    // for descriptors that yield nothing but may still be in flight.
    task automatic settle();
        push <= 1'b0;
        while (pending_mappings.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base_start(input logic [63:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        base_start_reg = value;
    endtask

    function automatic t_in_item descriptor(input logic [63:0] phys, input logic [51:0] pages,
                                            input logic [3:0] mtype, input logic [63:0] attr,
                                            input logic last);
        t_in_item d;
        d.phys_address = phys;
        d.page_count   = pages;
        d.mem_type     = mtype;
        d.attribute    = attr;
        d.last_of_map  = last;
        return d;
    endfunction

    function automatic logic [63:0] pick_base();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return BASE_RESET;
            3:       return {$urandom, $urandom} & ~(SZ_64K - 64'(1));
            4:       return 64'hFFFF_FFFF_FFE0_0000 + 64'($urandom_range(0, 32'h1F_FFFF));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly well-formed maps: ascending, often contiguous, cache bits kept
    // steady so regions join; a slice of pure noise on top.
    function automatic t_in_item next_descriptor();
        t_in_item    d;
        logic [51:0] pages;
        int unsigned pick;
        logic [31:0] rnd;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            d.phys_address = {$urandom, $urandom};
            d.page_count   = 52'({$urandom, $urandom});
            d.mem_type     = 4'($urandom);
            d.attribute    = {$urandom, $urandom};
            d.last_of_map  = 1'($urandom);
            return d;
        end
        if (gen_left == 0) begin
            gen_left  = $urandom_range(1, 12);
            gen_cache = 4'(1 << $urandom_range(0, 3));
            rnd       = $urandom;
            case ($urandom_range(0, 3))
                0:       gen_addr = {32'h0, rnd[31:12], 12'h000};
                1:       gen_addr = {$urandom, rnd[31:12], 12'h000};
                2:       gen_addr = 64'($urandom_range(0, 4095)) << SZ_2M_LOG2;
                default: gen_addr = 64'hFFFF_FFFF_FF00_0000 |
                                    (64'($urandom_range(0, 4095)) << PAGE_SHIFT);
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
            pages = '0;
        else if (pick < 20)
            pages = 52'($urandom_range(1, 4)) << 9;   // whole 2 MiB multiples
        else if (pick < 23)
            pages = 52'({$urandom, $urandom});
        else
            pages = 52'($urandom_range(1, 600));
        if ($urandom_range(0, 99) < 25)
            gen_addr = gen_addr + (64'($urandom_range(1, 64)) << PAGE_SHIFT);
        if ($urandom_range(0, 99) < 5)
            gen_cache = 4'($urandom);
        d.phys_address = gen_addr;
        d.page_count   = pages;
        d.mem_type     = 4'($urandom);
        d.attribute    = {$urandom, $urandom};
        d.attribute[RUNTIME_BIT] = ($urandom_range(0, 99) < 80);
        d.attribute[CACHE_BITS-1:0] = gen_cache;
        gen_left--;
        d.last_of_map = (gen_left == 0);
        gen_addr = gen_addr + {pages, 12'h000};
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // One map on the reset base: 2 MiB rounding, joining, cache change,
    // non-runtime previous region, 64 KiB offset, size extremes, end wrap.
    task automatic test_directed_map();
        send_descriptor(descriptor(64'h4000_0000, 52'd512, 4'd5, ATTR_RT | ATTR_WB, 1'b0));
        send_descriptor(descriptor(64'h4020_0000, 52'd16, 4'd5, ATTR_RT | ATTR_WB, 1'b0));
        send_descriptor(descriptor(64'h4021_0000, 52'd2, 4'd7, ATTR_RT | ATTR_UC, 1'b0));
        send_descriptor(descriptor(64'h4030_0000, 52'd3, 4'd1, ATTR_WB, 1'b0));
        send_descriptor(descriptor(64'h4030_3000, 52'd5, 4'd2, ATTR_RT | ATTR_WB, 1'b0));
        send_descriptor(descriptor(64'h4060_0000, 52'd256, 4'd3, ATTR_RT, 1'b0));
        send_descriptor(descriptor(64'h4080_0000, 52'd0, 4'd0, ATTR_RT, 1'b0));
        send_descriptor(descriptor(64'h4100_0000, '1, 4'd15, '1, 1'b0));
        send_descriptor(descriptor('1, 52'd1, 4'd9, ATTR_RT, 1'b0));
        send_descriptor(descriptor(64'h0, 52'd0, 4'd0, '0, 1'b1));
        // map of a single runtime region straight after the restart
        send_descriptor(descriptor(64'h1000, 52'd1, 4'd4, ATTR_RT | ATTR_WC, 1'b1));
    endtask

    // Register extremes: a base at the top of the space wraps when rounded.
    task automatic test_base_extremes();
        write_base_start('1);
        send_descriptor(descriptor(64'h20_0000, 52'd512, 4'd6, ATTR_RT | ATTR_WB, 1'b0));
        send_descriptor(descriptor(64'h40_0000, 52'd1, 4'd6, ATTR_RT | ATTR_WB, 1'b1));
        write_base_start('0);
        send_descriptor(descriptor(64'h0, 52'd0, 4'd0, ATTR_RT, 1'b1));
    endtask

    // A write inside a map only counts from the next map on.
    task automatic test_midmap_write();
        write_base_start(64'h1234_5678_9ABC_D000);
        send_descriptor(descriptor(64'h8000_0000, 52'd4, 4'd8, ATTR_RT | ATTR_WB, 1'b0));
        write_base_start(64'h0000_7000_0000_0000);
        send_descriptor(descriptor(64'h8000_4000, 52'd4, 4'd8, ATTR_RT | ATTR_WB, 1'b1));
        send_descriptor(descriptor(64'h9000_0000, 52'd1, 4'd8, ATTR_RT | ATTR_WB, 1'b1));
    endtask

    task automatic test_random_maps(input int unsigned items);
        for (int unsigned i = 0; i < items; i++) begin
            if (i % 130 == 129)
                write_base_start(pick_base());
            send_descriptor(next_descriptor());
        end
    endtask

    // Result side holds off while descriptors keep coming: the block fills
    // and must stall its input without losing a transfer.
    task automatic test_backpressure();
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 20;
        hold_left = STALL_CYCLES;
        for (int unsigned i = 0; i < 64; i++)
            send_descriptor(descriptor(64'hA000_0000 + (64'(i) << PAGE_SHIFT), 52'd1,
                                       4'(i), ATTR_RT | ATTR_WB, i == 63));
    endtask

    initial begin
        base_start_reg = BASE_RESET;
        restart_map_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_map();
        test_base_extremes();
        test_midmap_write();

        // sender mostly busy, receiver mostly idle
        send_idle_pct = 14;
        recv_idle_pct = 60;
        test_random_maps(620);
        // and the other way round
        send_idle_pct = 60;
        recv_idle_pct = 14;
        test_random_maps(620);
        // flat out
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_maps(620);

        test_backpressure();

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
